/* sv/whew_pkg.sv */
// Shared types, constants and helper functions of the worker hang watchdog.
package whew_pkg;

  // Table size and field widths
  localparam int NUM_WORKERS   = 64;
  localparam int NUM_LEVELS    = 7;
  localparam int SECONDS_WIDTH = 24;

  localparam int IDX_W      = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int WIDX_W     = 6;
  localparam int TASK_W     = 32;
  localparam int CNT_W      = 8;
  localparam int LVL_W      = 3;
  localparam int OUT_SECS_W = 24;

  // Stream payload layout
  localparam int IN_TDATA_W   = 40;
  localparam int IN_MON_POS   = WIDX_W;
  localparam int IN_BUSY_POS  = WIDX_W + 1;
  localparam int IN_TASK_LSB  = WIDX_W + 2;
  localparam int OUT_TDATA_W  = 32;
  localparam int OUT_SECS_LSB = WIDX_W;
  localparam int OUT_TUSER_W  = 2;

  localparam logic [CNT_W-1:0]      SPS_RESET   = CNT_W'(2);
  localparam logic [LVL_W-1:0]      LAST_LEVEL  = LVL_W'(NUM_LEVELS - 1);
  localparam logic [OUT_SECS_W-1:0] OUT_SEC_MAX = '1;

  // Hang report intervals in seconds, one per escalation level
  localparam int unsigned LEVEL_INTERVAL [8] = '{1, 5, 10, 30, 60, 600, 1800, 1800};

  // Each interval divides the next, so held seconds are kept as a mixed-radix
  // counter: digit k counts in steps of LEVEL_INTERVAL[k] up to the next one.
  localparam int unsigned LEVEL_RADIX [8] = '{
    1,
    LEVEL_INTERVAL[1] / LEVEL_INTERVAL[0],
    LEVEL_INTERVAL[2] / LEVEL_INTERVAL[1],
    LEVEL_INTERVAL[3] / LEVEL_INTERVAL[2],
    LEVEL_INTERVAL[4] / LEVEL_INTERVAL[3],
    LEVEL_INTERVAL[5] / LEVEL_INTERVAL[4],
    LEVEL_INTERVAL[6] / LEVEL_INTERVAL[5],
    LEVEL_INTERVAL[7] / LEVEL_INTERVAL[6]
  };

  function automatic int unsigned max_radix();
    int unsigned m;
    m = 2;
    for (int k = 1; k < 8; k++) begin
      if (LEVEL_RADIX[k] > m) m = LEVEL_RADIX[k];
    end
    return m;
  endfunction

  localparam int NUM_DIG = (NUM_LEVELS > 1) ? NUM_LEVELS - 1 : 1;
  localparam int DIGIT_W = $clog2(max_radix());

  typedef logic [NUM_DIG-1:0][DIGIT_W-1:0] digits_t;

  // One table entry
  typedef struct packed {
    logic [TASK_W-1:0]        tracked_task;
    logic [CNT_W-1:0]         count;
    logic [SECONDS_WIDTH-1:0] secs;
    logic [LVL_W-1:0]         level;
    digits_t                  digs;
  } entry_t;

  // Controller to datapath commands and datapath status
  typedef struct packed {
    logic capture;
    logic commit;
  } whew_cmd_t;

  typedef struct packed {
    logic out_free;
  } whew_stat_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EVAL
  } state_t;

  // Advance the mixed-radix seconds counter by one
  function automatic digits_t inc_digits(input digits_t d);
    digits_t r;
    logic    carry;
    r     = d;
    carry = 1'b1;
    for (int k = 0; k < NUM_DIG; k++) begin
      if (carry) begin
        if (d[k] == DIGIT_W'(LEVEL_RADIX[k+1] - 1)) begin
          r[k] = '0;
        end else begin
          r[k]  = d[k] + DIGIT_W'(1);
          carry = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Clamp held seconds to the width of the result field
  function automatic logic [OUT_SECS_W-1:0] sat_out(input logic [SECONDS_WIDTH-1:0] s);
    logic [32:0] ext;
    ext = 33'(s);
    if (ext > 33'(OUT_SEC_MAX)) return OUT_SEC_MAX;
    return ext[OUT_SECS_W-1:0];
  endfunction

endpackage

/* sv/worker_hang_escalating_watchdog.sv */
// Top level of the worker hang watchdog: controller, datapath and port packing.
//
//   Channel | Direction | tdata                                          | tuser
//   in_     | slave     | worker_index, monitored, busy_req, task_id     | command
//   out_    | master    | sampled_worker, held_seconds                   | hang_report, task_finished
//   cfg_    | slave     | samples_per_second                             | -
//
// Each item is handled in ST_IDLE, with the transfer and the table read, then in
// ST_EVAL, with the update and write-back of the entry, set by the single-port entry memory.
// A result waiting on out_ holds ST_EVAL until the result register frees.
// The next item is taken while the previous result still waits to be transferred.
// Reset (rst_n low) invalidates all entries at once and sets samples_per_second to 2.
module worker_hang_escalating_watchdog import whew_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [5:0] worker_index, [6] monitored, [7] busy_req, [39:8] task_id
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] command
  input  logic                   in_tuser,
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [5:0] sampled_worker, [29:6] held_seconds, [31:30] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] hang_report, [1] task_finished
  output logic [OUT_TUSER_W-1:0] out_tuser,
  // Configuration
  input  logic                   cfg_tvalid,
  output logic                   cfg_tready,
  // [7:0] samples_per_second
  input  logic [CNT_W-1:0]       cfg_tdata
);

  whew_cmd_t             cmd;
  whew_stat_t            stat;
  logic [WIDX_W-1:0]     out_worker;
  logic                  out_hang;
  logic                  out_fin;
  logic [OUT_SECS_W-1:0] out_secs;

  // Configuration is always taken
  assign cfg_tready = 1'b1;

  whew_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  whew_dpath u_dpath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .stat                   (stat),
    .in_command             (in_tuser),
    .in_worker_index        (in_tdata[WIDX_W-1:0]),
    .in_monitored           (in_tdata[IN_MON_POS]),
    .in_busy_req            (in_tdata[IN_BUSY_POS]),
    .in_task_id             (in_tdata[IN_TASK_LSB +: TASK_W]),
    .cfg_we                 (cfg_tvalid && cfg_tready),
    .cfg_samples_per_second (cfg_tdata),
    .out_tvalid             (out_tvalid),
    .out_tready             (out_tready),
    .out_sampled_worker     (out_worker),
    .out_hang_report        (out_hang),
    .out_task_finished      (out_fin),
    .out_held_seconds       (out_secs)
  );

  // Result packing
  assign out_tdata = OUT_TDATA_W'({out_secs, out_worker});
  assign out_tuser = {out_fin, out_hang};

endmodule

/* sv/whew_ctrl.sv */
// Sequencing state machine of the worker hang watchdog.
module whew_ctrl import whew_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  whew_stat_t stat,
  output whew_cmd_t  cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands: take an item, then read-modify-write its entry
  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* sv/whew_dpath.sv */
// Datapath of the worker hang watchdog: entry table, update logic, result register.
module whew_dpath import whew_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  whew_cmd_t                cmd,
  output whew_stat_t               stat,
  input  logic                     in_command,
  input  logic [WIDX_W-1:0]        in_worker_index,
  input  logic                     in_monitored,
  input  logic                     in_busy_req,
  input  logic [TASK_W-1:0]        in_task_id,
  input  logic                     cfg_we,
  input  logic [CNT_W-1:0]         cfg_samples_per_second,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [WIDX_W-1:0]        out_sampled_worker,
  output logic                     out_hang_report,
  output logic                     out_task_finished,
  output logic [OUT_SECS_W-1:0]    out_held_seconds
);

  // Captured item and configuration
  logic              cmd_r;
  logic [WIDX_W-1:0] widx_r;
  logic              mon_r;
  logic              busy_r;
  logic [TASK_W-1:0] task_r;
  logic [CNT_W-1:0]  sps_r;

  // Entry table with valid bits
  entry_t           mem [NUM_WORKERS];
  entry_t           rd_entry_r;
  logic             valid_r [NUM_WORKERS];

  // Result register
  logic                  out_tvalid_r;
  logic [WIDX_W-1:0]     out_worker_r;
  logic                  out_hang_r;
  logic                  out_fin_r;
  logic [OUT_SECS_W-1:0] out_secs_r;

  // Update logic signals
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      addr;
  logic                  in_range;
  logic                  vld;
  entry_t                new_e;
  logic                  we;
  logic                  set_valid;
  logic                  clr_valid;
  logic                  clr_all;
  logic                  hang;
  logic                  fin;
  logic [OUT_SECS_W-1:0] secs;
  logic [CNT_W-1:0]      need;
  logic [CNT_W:0]        cnt;
  logic [LVL_W-1:0]      lvl_c;
  logic [SECONDS_WIDTH-1:0] s_inc;
  digits_t               digs_n;
  logic                  hit;

  assign rd_addr  = IDX_W'(in_worker_index);
  assign addr     = IDX_W'(widx_r);
  assign in_range = (32'(widx_r) < 32'(NUM_WORKERS));
  assign vld      = in_range && valid_r[addr];

  // Capture the item on its transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_command;
      widx_r <= in_worker_index;
      mon_r  <= in_monitored;
      busy_r <= in_busy_req;
      task_r <= in_task_id;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sps_r <= SPS_RESET;
    end else if (cfg_we) begin
      sps_r <= cfg_samples_per_second;
    end
  end

  // Table memory: registered read on capture, write on commit of an updated entry
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_entry_r <= mem[rd_addr];
    end
    if (cmd.commit && we) begin
      mem[addr] <= new_e;
    end
  end

  // Entry update
  always_comb begin
    new_e     = rd_entry_r;
    we        = 1'b0;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    clr_all   = 1'b0;
    hang      = 1'b0;
    fin       = 1'b0;
    secs      = '0;
    need      = (sps_r == '0) ? CNT_W'(1) : sps_r;
    cnt       = {1'b0, rd_entry_r.count} + (CNT_W+1)'(1);
    lvl_c     = (rd_entry_r.level > LAST_LEVEL) ? LAST_LEVEL : rd_entry_r.level;
    s_inc     = rd_entry_r.secs + SECONDS_WIDTH'(1);
    digs_n    = inc_digits(rd_entry_r.digs);
    // Threshold reached when all digits below the current level are zero
    hit = 1'b1;
    for (int k = 0; k < NUM_DIG; k++) begin
      if ((k < int'(lvl_c)) && (digs_n[k] != '0)) hit = 1'b0;
    end

    if (cmd_r) begin
      clr_all = 1'b1;
    end else if (mon_r && in_range) begin
      if (!busy_r) begin
        clr_valid = 1'b1;
      end else if (!vld || (rd_entry_r.tracked_task != task_r)) begin
        // New task on this worker: report the old one if it held time
        if (vld && (rd_entry_r.secs != '0)) begin
          fin  = 1'b1;
          secs = sat_out(rd_entry_r.secs);
        end
        new_e.tracked_task = task_r;
        new_e.count        = '0;
        new_e.secs         = '0;
        new_e.level        = '0;
        new_e.digs         = '0;
        we                 = 1'b1;
        set_valid          = 1'b1;
      end else begin
        we = 1'b1;
        if (cnt < {1'b0, need}) begin
          new_e.count = cnt[CNT_W-1:0];
        end else begin
          new_e.count = '0;
          if (rd_entry_r.secs != '1) begin
            new_e.secs = s_inc;
            new_e.digs = digs_n;
            if (hit) begin
              hang = 1'b1;
              secs = sat_out(s_inc);
              if (lvl_c < LAST_LEVEL) lvl_c = lvl_c + LVL_W'(1);
            end
            new_e.level = lvl_c;
          end
        end
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WORKERS; i++) valid_r[i] <= 1'b0;
    end else if (cmd.commit) begin
      if (clr_all) begin
        for (int i = 0; i < NUM_WORKERS; i++) valid_r[i] <= 1'b0;
      end else if (set_valid) begin
        valid_r[addr] <= 1'b1;
      end else if (clr_valid) begin
        valid_r[addr] <= 1'b0;
      end
    end
  end

  // Result register: loaded on commit, freed by the output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_worker_r <= cmd_r ? '0 : widx_r;
      out_hang_r   <= hang;
      out_fin_r    <= fin;
      out_secs_r   <= secs;
    end
  end

  assign stat.out_free      = !out_tvalid_r || out_tready;
  assign out_tvalid         = out_tvalid_r;
  assign out_sampled_worker = out_worker_r;
  assign out_hang_report    = out_hang_r;
  assign out_task_finished  = out_fin_r;
  assign out_held_seconds   = out_secs_r;

endmodule

/* sv/whew_checker.sv */
// Port-level checker of the worker hang watchdog and its bind to the top level.
module whew_checker import whew_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // One item at a time: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  // Hang and finished reports never come together
  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("both report flags set");

  // A report always carries held time
  a_flag_secs: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] || out_tuser[1])
      |-> out_tdata[OUT_SECS_LSB +: OUT_SECS_W] != '0)
    else $error("report with zero seconds");

  // A plain result carries no time
  a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] && !out_tuser[1]
      |-> out_tdata[OUT_SECS_LSB +: OUT_SECS_W] == '0)
    else $error("seconds without a report");

endmodule

bind worker_hang_escalating_watchdog whew_checker u_whew_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
